### src/epm_pkg.sv
package epm_pkg;

    // Coordinate, kernel and pixel widths fixed by the interface
    localparam int COORD_W = 8;
    localparam int KERN_W  = 4;
    localparam int PIX_W   = 8;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INSIDE_THRESHOLD = 2'd3;

    // Configuration reset values
    localparam logic [7:0]        RST_IMAGE_WIDTH      = 8'd128;
    localparam logic [7:0]        RST_IMAGE_HEIGHT     = 8'd128;
    localparam logic [KERN_W-1:0] RST_KERNEL_SIZE      = 4'd4;
    localparam logic [PIX_W-1:0]  RST_INSIDE_THRESHOLD = 8'd175;

    // Request codes
    localparam logic REQ_WRITE   = 1'b0;
    localparam logic REQ_COMPUTE = 1'b1;

    // floor(255 / K) for K = 0..15; entry 0 is never selected
    localparam logic [PIX_W-1:0] STEP_TABLE [16] = '{
        8'd255, 8'd255, 8'd127, 8'd85, 8'd63, 8'd51, 8'd42, 8'd36,
        8'd31,  8'd28,  8'd25,  8'd23, 8'd21, 8'd19, 8'd18, 8'd17
    };

    typedef enum logic [1:0] {
        S_IDLE,
        S_CENTER,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

### src/edge_proximity_map_top.sv
// Edge proximity map.
// Holds a single-channel 8-bit image in one single-port pixel memory
// (address y*MAX_WIDTH+x) and answers proximity queries against it.
// Input channel (i_in_valid / o_in_ready): a write transaction stores one
// pixel and produces no result; a compute transaction classes
// the named pixel against the threshold, scans the clipped window of up to
// 2K x 2K neighbors and returns (K-k)*floor(255/K), k being the nearest
// opposite-class Chebyshev distance capped at K.
// A compute reads the center pixel, then the window one pixel per cycle
// through the single memory port, and loads the result register once the
// output slot is free. A query outside the configured image goes straight
// to the done state and returns 0. One item is worked on at a time: the
// block is ready for the next as the result loads; writes go every cycle.
// Output channel (o_out_valid / i_out_ready): a result register holds the
// value until taken; a new item is accepted while it waits, and a finished
// compute holds in its last state while the receiver stalls.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready): index
// 0 width, 1 height, 2 kernel size, 3 threshold; write only when idle.
// Reset restores configuration defaults and clears control state; pixel
// memory contents stay undefined until written, with no clearing pass.
module edge_proximity_map_top #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128,
    parameter int MAX_KERNEL = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_req_type,
    input  logic [6:0]                      i_pos_x,
    input  logic [6:0]                      i_pos_y,
    input  logic [7:0]                      i_pixel_value,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [7:0]                      o_proximity_value,
    // configuration channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [epm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [7:0]                      i_cfg_data
);

    localparam int CW    = epm_pkg::COORD_W;
    localparam int KW    = epm_pkg::KERN_W;
    localparam int PW    = epm_pkg::PIX_W;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int PRODW = KW + PW;

    // Linear pixel address
    function automatic logic [AW-1:0] pix_addr(input logic [CW-1:0] x,
                                               input logic [CW-1:0] y);
        return AW'(y) * AW'(MAX_WIDTH) + AW'(x);
    endfunction

    // Configuration registers
    logic [7:0]    r_cfg_width;
    logic [7:0]    r_cfg_height;
    logic [KW-1:0] r_cfg_kernel;
    logic [PW-1:0] r_cfg_thr;

    // Control registers
    epm_pkg::t_state r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic r_pv, n_pv;
    logic r_issue_done, n_issue_done;

    // Payload registers
    logic [CW-1:0] r_x, n_x, r_y, n_y;
    logic [CW-1:0] r_xlo, n_xlo, r_xhi, n_xhi, r_ylo, n_ylo, r_yhi, n_yhi;
    logic [CW-1:0] r_nx, n_nx, r_ny, n_ny;
    logic [CW-1:0] r_px, n_px, r_py, n_py;
    logic [KW-1:0] r_kr, n_kr, r_best, n_best;
    logic          r_inside, n_inside;
    logic [PW-1:0] r_out_data, n_out_data;

    // Pixel memory
    logic [PW-1:0] mem [DEPTH];
    logic [PW-1:0] r_rd_data;
    logic [AW-1:0] mem_addr;
    logic          mem_we;

    // Handshake and decode
    logic          in_fire, out_free, is_compute, in_store, in_range, issue;
    logic [CW-1:0] cur_w, cur_h, in_x, in_y;
    logic [KW-1:0] cur_kr;
    logic [CW-1:0] dx, dy, nb_dist;
    logic          nb_inside;
    logic [PRODW-1:0] product;

    assign o_in_ready  = (r_state == epm_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_proximity_value = r_out_data;

    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign is_compute = (i_req_type == epm_pkg::REQ_COMPUTE);
    assign in_x       = CW'(i_pos_x);
    assign in_y       = CW'(i_pos_y);
    assign in_store   = (32'(i_pos_x) < MAX_WIDTH) && (32'(i_pos_y) < MAX_HEIGHT);

    // Clamp configuration to legal ranges
    always_comb begin
        if (r_cfg_width == '0) begin
            cur_w = CW'(1);
        end else if (32'(r_cfg_width) > MAX_WIDTH) begin
            cur_w = CW'(MAX_WIDTH);
        end else begin
            cur_w = r_cfg_width;
        end
        if (r_cfg_height == '0) begin
            cur_h = CW'(1);
        end else if (32'(r_cfg_height) > MAX_HEIGHT) begin
            cur_h = CW'(MAX_HEIGHT);
        end else begin
            cur_h = r_cfg_height;
        end
        if (r_cfg_kernel == '0) begin
            cur_kr = KW'(1);
        end else if (32'(r_cfg_kernel) > MAX_KERNEL) begin
            cur_kr = KW'(MAX_KERNEL);
        end else begin
            cur_kr = r_cfg_kernel;
        end
    end

    assign in_range = (in_x < cur_w) && (in_y < cur_h);
    assign issue = ((r_state == epm_pkg::S_CENTER) || (r_state == epm_pkg::S_SCAN))
                   && !r_issue_done;

    // Memory port: input address while idle, scan address otherwise
    assign mem_addr = (r_state == epm_pkg::S_IDLE) ? pix_addr(in_x, in_y)
                                                   : pix_addr(r_nx, r_ny);
    assign mem_we   = in_fire && !is_compute && in_store;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= i_pixel_value;
        end
        r_rd_data <= mem[mem_addr];
    end

    // Distance of the pixel whose data is now on the read port
    assign dx        = (r_px > r_x) ? (r_px - r_x) : (r_x - r_px);
    assign dy        = (r_py > r_y) ? (r_py - r_y) : (r_y - r_py);
    assign nb_dist   = (dx > dy) ? dx : dy;
    assign nb_inside = (r_rd_data > r_cfg_thr);
    assign product   = PRODW'(r_kr - r_best) * PRODW'(epm_pkg::STEP_TABLE[r_kr]);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            epm_pkg::S_IDLE: begin
                if (in_fire && is_compute) begin
                    n_state = in_range ? epm_pkg::S_CENTER : epm_pkg::S_DONE;
                end
            end
            epm_pkg::S_CENTER: begin
                n_state = epm_pkg::S_SCAN;
            end
            epm_pkg::S_SCAN: begin
                if (r_issue_done && !r_pv) begin
                    n_state = epm_pkg::S_DONE;
                end
            end
            epm_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = epm_pkg::S_IDLE;
                end
            end
            default: n_state = epm_pkg::S_IDLE;
        endcase
    end

    // Datapath next values
    always_comb begin
        n_x = r_x;       n_y = r_y;
        n_xlo = r_xlo;   n_xhi = r_xhi;
        n_ylo = r_ylo;   n_yhi = r_yhi;
        n_nx = r_nx;     n_ny = r_ny;
        n_px = r_px;     n_py = r_py;
        n_kr = r_kr;     n_best = r_best;
        n_inside = r_inside;
        n_issue_done = r_issue_done;
        n_pv = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data = r_out_data;

        // latch a compute request and its clipped window
        if ((r_state == epm_pkg::S_IDLE) && in_fire && is_compute) begin
            n_x    = in_x;
            n_y    = in_y;
            n_kr   = cur_kr;
            n_best = cur_kr;
            n_xlo  = (in_x > CW'(cur_kr)) ? (in_x - CW'(cur_kr)) : '0;
            n_ylo  = (in_y > CW'(cur_kr)) ? (in_y - CW'(cur_kr)) : '0;
            n_xhi  = ((in_x + CW'(cur_kr)) > cur_w) ? cur_w : (in_x + CW'(cur_kr));
            n_yhi  = ((in_y + CW'(cur_kr)) > cur_h) ? cur_h : (in_y + CW'(cur_kr));
            n_nx   = n_xlo;
            n_ny   = n_ylo;
            n_issue_done = 1'b0;
        end

        // class of the queried pixel
        if (r_state == epm_pkg::S_CENTER) begin
            n_inside = nb_inside;
        end

        // issue one window read and advance the raster counters
        if (issue) begin
            n_pv = 1'b1;
            n_px = r_nx;
            n_py = r_ny;
            if ((r_nx + CW'(1)) == r_xhi) begin
                n_nx = r_xlo;
                if ((r_ny + CW'(1)) == r_yhi) begin
                    n_issue_done = 1'b1;
                end else begin
                    n_ny = r_ny + CW'(1);
                end
            end else begin
                n_nx = r_nx + CW'(1);
            end
        end

        // keep the nearest opposite-class distance
        if ((r_state == epm_pkg::S_SCAN) && r_pv) begin
            if ((nb_inside != r_inside) && (nb_dist < CW'(r_best))) begin
                n_best = KW'(nb_dist);
            end
        end

        // hand the result to the output register
        if ((r_state == epm_pkg::S_DONE) && out_free) begin
            n_out_valid = 1'b1;
            n_out_data  = product[PW-1:0];
        end
    end

    // Control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= epm_pkg::S_IDLE;
            r_out_valid  <= 1'b0;
            r_pv         <= 1'b0;
            r_issue_done <= 1'b1;
            r_cfg_width  <= epm_pkg::RST_IMAGE_WIDTH;
            r_cfg_height <= epm_pkg::RST_IMAGE_HEIGHT;
            r_cfg_kernel <= epm_pkg::RST_KERNEL_SIZE;
            r_cfg_thr    <= epm_pkg::RST_INSIDE_THRESHOLD;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_pv         <= n_pv;
            r_issue_done <= n_issue_done;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    epm_pkg::CFG_IMAGE_WIDTH:      r_cfg_width  <= i_cfg_data;
                    epm_pkg::CFG_IMAGE_HEIGHT:     r_cfg_height <= i_cfg_data;
                    epm_pkg::CFG_KERNEL_SIZE:      r_cfg_kernel <= i_cfg_data[KW-1:0];
                    epm_pkg::CFG_INSIDE_THRESHOLD: r_cfg_thr    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_x <= n_x;       r_y <= n_y;
        r_xlo <= n_xlo;   r_xhi <= n_xhi;
        r_ylo <= n_ylo;   r_yhi <= n_yhi;
        r_nx <= n_nx;     r_ny <= n_ny;
        r_px <= n_px;     r_py <= n_py;
        r_kr <= n_kr;     r_best <= n_best;
        r_inside <= n_inside;
        r_out_data <= n_out_data;
    end

    // Finished compute with a free output slot always lands a result
    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == epm_pkg::S_DONE) && out_free |=> r_out_valid)
        else $error("finished compute did not load the result register");

    // Measured distance never exceeds the kernel cap
    a_best_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != epm_pkg::S_IDLE) |-> (r_best <= r_kr))
        else $error("best distance above kernel size");

    // A pixel write returns straight to idle without a result
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && !is_compute |=> (r_state == epm_pkg::S_IDLE)
                                   && (r_out_valid == $past(n_out_valid)))
        else $error("pixel write disturbed state or output");

    // Every scanned pixel lies inside the clipped window
    a_scan_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == epm_pkg::S_SCAN) && r_pv |-> (r_px >= r_xlo) && (r_px < r_xhi)
                                                && (r_py >= r_ylo) && (r_py < r_yhi))
        else $error("scan address outside window");

endmodule

### test/edge_proximity_map_top_tb.sv
module edge_proximity_map_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IMG_W           = 128;
    localparam int IMG_H           = 128;
    localparam int FILL_W          = 16;
    localparam int FILL_H          = 16;
    localparam int KERN_MAX        = 8;
    localparam int NUM_PHASES      = 4;
    localparam int ITEMS_PER_PHASE = 32;
    localparam int HOLDOFF_START   = 8;
    localparam int HOLDOFF_CYCLES  = 1500;
    localparam int SETTLE_CYCLES   = 8;
    localparam int TAIL_CYCLES     = 300;

    // Short names for the codes used in the directed table
    localparam logic [epm_pkg::CFG_IDX_W-1:0] IDX_W = epm_pkg::CFG_IMAGE_WIDTH;
    localparam logic [epm_pkg::CFG_IDX_W-1:0] IDX_H = epm_pkg::CFG_IMAGE_HEIGHT;
    localparam logic [epm_pkg::CFG_IDX_W-1:0] IDX_K = epm_pkg::CFG_KERNEL_SIZE;
    localparam logic [epm_pkg::CFG_IDX_W-1:0] IDX_T = epm_pkg::CFG_INSIDE_THRESHOLD;
    localparam logic WR  = epm_pkg::REQ_WRITE;
    localparam logic CMP = epm_pkg::REQ_COMPUTE;

    // Register settings and idle rates of the random phases; the image stays
    // inside the filled corner so every scanned pixel has been written
    localparam logic [7:0] PHASE_WIDTH      [NUM_PHASES] = '{8'd16, 8'd7, 8'd16, 8'd11};
    localparam logic [7:0] PHASE_HEIGHT     [NUM_PHASES] = '{8'd16, 8'd10, 8'd6, 8'd16};
    localparam logic [7:0] PHASE_KERNEL     [NUM_PHASES] = '{8'd8, 8'd3, 8'd5, 8'd15};
    localparam logic [7:0] PHASE_THRESHOLD  [NUM_PHASES] = '{8'd175, 8'd100, 8'd200, 8'd90};
    localparam int         PHASE_SEND_IDLE  [NUM_PHASES] = '{0, 88, 0, 36};
    localparam int         PHASE_RECV_STALL [NUM_PHASES] = '{0, 0, 88, 36};

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    // One directed row: a register write or an input transaction
    typedef struct packed {
        t_row_kind                      kind;
        logic [epm_pkg::CFG_IDX_W-1:0]  cfg_index;
        logic [7:0]                     cfg_data;
        logic                           req;
        logic [6:0]                     pos_x;
        logic [6:0]                     pos_y;
        logic [7:0]                     pixel;
        logic                           use_known;
        logic [7:0]                     known_value;
    } t_directed_row;

    // Index and data are don't-care on item rows, transaction fields on register rows
    localparam t_directed_row DIRECTED_ROWS [23] = '{
        '{ROW_ITEM, IDX_W, 8'd0, WR, 7'd0, 7'd0, 8'h00, 1'b0, 8'd0},
        '{ROW_ITEM, IDX_W, 8'd0, WR, 7'd12, 7'd12, 8'hFF, 1'b0, 8'd0},
        '{ROW_ITEM, IDX_W, 8'd0, WR, 7'd11, 7'd12, 8'h00, 1'b0, 8'd0},
        '{ROW_ITEM, IDX_W, 8'd0, CMP, 7'd12, 7'd12, 8'h00, 1'b0, 8'd0},
        '{ROW_ITEM, IDX_W, 8'd0, CMP, 7'd0, 7'd0, 8'h00, 1'b0, 8'd0},
        // zero width and height act as a 1x1 image
        '{ROW_CFG, IDX_W, 8'd0, WR, 7'd0, 7'd0, 8'h00, 1'b0, 8'd0},
        '{ROW_CFG, IDX_H, 8'd0, WR, 7'd0, 7'd0, 8'h00, 1'b0, 8'd0},
        '{ROW_ITEM, IDX_W, 8'd0, CMP, 7'd0, 7'd0, 8'h00, 1'b1, 8'd0},
        // write beyond the configured image still lands in the store
        '{ROW_ITEM, IDX_W, 8'd0, WR, 7'd1, 7'd0, 8'd250, 1'b0, 8'd0},
        '{ROW_ITEM, IDX_W, 8'd0, CMP, 7'd1, 7'd0, 8'h00, 1'b1, 8'd0},
        '{ROW_ITEM, IDX_W, 8'd0, CMP, 7'd0, 7'd127, 8'h00, 1'b1, 8'd0},
        '{ROW_ITEM, IDX_W, 8'd0, CMP, 7'd127, 7'd127, 8'h00, 1'b1, 8'd0},
        // oversize dimensions saturate, a zero kernel acts as radius one
        '{ROW_CFG, IDX_W, 8'd255, WR, 7'd0, 7'd0, 8'h00, 1'b0, 8'd0},
        '{ROW_CFG, IDX_H, 8'd200, WR, 7'd0, 7'd0, 8'h00, 1'b0, 8'd0},
        '{ROW_CFG, IDX_K, 8'd0, WR, 7'd0, 7'd0, 8'h00, 1'b0, 8'd0},
        '{ROW_ITEM, IDX_W, 8'd0, CMP, 7'd5, 7'd5, 8'h00, 1'b1, 8'd0},
        // upper data bits drop, leaving the maximum kernel of 8; nothing exceeds 255
        '{ROW_CFG, IDX_K, 8'hF8, WR, 7'd0, 7'd0, 8'h00, 1'b0, 8'd0},
        '{ROW_CFG, IDX_T, 8'd255, WR, 7'd0, 7'd0, 8'h00, 1'b0, 8'd0},
        '{ROW_ITEM, IDX_W, 8'd0, CMP, 7'd8, 7'd8, 8'h00, 1'b1, 8'd0},
        '{ROW_CFG, IDX_T, 8'd0, WR, 7'd0, 7'd0, 8'h00, 1'b0, 8'd0},
        '{ROW_ITEM, IDX_W, 8'd0, CMP, 7'd1, 7'd0, 8'h00, 1'b0, 8'd0},
        '{ROW_ITEM, IDX_W, 8'd0, WR, 7'd8, 7'd8, 8'h00, 1'b0, 8'd0},
        '{ROW_ITEM, IDX_W, 8'd0, CMP, 7'd8, 7'd8, 8'h00, 1'b0, 8'd0}
    };

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_in_valid    = 1'b0;
    logic                          o_in_ready;
    logic                          i_req_type    = epm_pkg::REQ_WRITE;
    logic [6:0]                    i_pos_x       = '0;
    logic [6:0]                    i_pos_y       = '0;
    logic [7:0]                    i_pixel_value = '0;
    logic                          o_out_valid;
    logic                          i_out_ready   = 1'b0;
    logic [7:0]                    o_proximity_value;
    logic                          i_cfg_valid   = 1'b0;
    logic                          o_cfg_ready;
    logic [epm_pkg::CFG_IDX_W-1:0] i_cfg_index   = epm_pkg::CFG_IMAGE_WIDTH;
    logic [7:0]                    i_cfg_data    = '0;

    // Mirror of the pixel store and the register file
    logic [7:0]                 pixel_mirror [IMG_W*IMG_H];
    logic [7:0]                 cfg_width     = epm_pkg::RST_IMAGE_WIDTH;
    logic [7:0]                 cfg_height    = epm_pkg::RST_IMAGE_HEIGHT;
    logic [epm_pkg::KERN_W-1:0] cfg_kernel    = epm_pkg::RST_KERNEL_SIZE;
    logic [7:0]                 cfg_threshold = epm_pkg::RST_INSIDE_THRESHOLD;

    logic [7:0] expected_proximity_q [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int holdoff_req    = 0;
    int holdoff_seen   = 0;
    int holdoff_left   = 0;

    edge_proximity_map_top i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_req_type        (i_req_type),
        .i_pos_x           (i_pos_x),
        .i_pos_y           (i_pos_y),
        .i_pixel_value     (i_pixel_value),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_proximity_value (o_proximity_value),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Map zero to one and saturate at the maximum
    function automatic int clamp_dim(input int v, input int hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    // Nearest opposite-class pixel in the clipped window, scaled to a byte
    function automatic logic [7:0] predict_proximity(input int px, input int py);
        int   w, h, kr, best, dx, dy, cheb;
        logic center_in;
        w  = clamp_dim(cfg_width, IMG_W);
        h  = clamp_dim(cfg_height, IMG_H);
        kr = clamp_dim(cfg_kernel, KERN_MAX);
        if (px >= w || py >= h) return 8'd0;
        center_in = pixel_mirror[py*IMG_W + px] > cfg_threshold;
        best = kr;
        for (int ny = (py > kr ? py - kr : 0); ny < (py + kr > h ? h : py + kr); ny++) begin
            for (int nx = (px > kr ? px - kr : 0); nx < (px + kr > w ? w : px + kr); nx++) begin
                if ((pixel_mirror[ny*IMG_W + nx] > cfg_threshold) != center_in) begin
                    dx   = (nx > px) ? nx - px : px - nx;
                    dy   = (ny > py) ? ny - py : py - ny;
                    cheb = (dx > dy) ? dx : dy;
                    if (cheb < best) best = cheb;
                end
            end
        end
        return 8'((kr - best) * (255 / kr));
    endfunction

    // Mostly inside the configured extent, sometimes anywhere in the store
    function automatic logic [6:0] pick_coord(input int lim);
        if ($urandom_range(0, 99) < 85) return 7'($urandom_range(0, lim - 1));
        return 7'($urandom_range(0, 127));
    endfunction

    // Offer one transaction, hold it until accepted, then update the mirror or queue the expected result
    task automatic send_item(input logic req, input logic [6:0] x, input logic [6:0] y,
                             input logic [7:0] pv, input logic use_known,
                             input logic [7:0] known_value);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_req_type    = req;
        i_pos_x       = x;
        i_pos_y       = y;
        i_pixel_value = pv;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (req == epm_pkg::REQ_WRITE) pixel_mirror[int'(y)*IMG_W + int'(x)] = pv;
        else expected_proximity_q.push_back(use_known ? known_value : predict_proximity(x, y));
    endtask

    // Drop valid and wait until every result is back and the block settles
    task automatic drain_block();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_proximity_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [epm_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [7:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            epm_pkg::CFG_IMAGE_WIDTH:      cfg_width     = data;
            epm_pkg::CFG_IMAGE_HEIGHT:     cfg_height    = data;
            epm_pkg::CFG_KERNEL_SIZE:      cfg_kernel    = data[epm_pkg::KERN_W-1:0];
            epm_pkg::CFG_INSIDE_THRESHOLD: cfg_threshold = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Drive result ready: long hold-off when requested, else random stalls
    always @(negedge i_clk) begin
        if (holdoff_req != holdoff_seen) begin
            holdoff_seen = holdoff_req;
            holdoff_left = HOLDOFF_CYCLES;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            i_out_ready = 1'b0;
        end else begin
            i_out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin : check_result
        logic [7:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_proximity_q.size() == 0) begin
                $display("%0t: proximity_value expected none, actual %0d",
                         $time, o_proximity_value);
                error_count++;
            end else begin
                want = expected_proximity_q.pop_front();
                if (o_proximity_value !== want) begin
                    $display("%0t: proximity_value expected %0d, actual %0d",
                             $time, want, o_proximity_value);
                    error_count++;
                end
            end
        end
    end

    initial begin : stimulus
        logic [7:0] pv;
        logic [6:0] cx, cy;
        int         w, h, kr, thr, roll, t, n;
        bit         holdoff_done;

        holdoff_done = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Fill the scanned corner: a dark patch, banded blocks and noise elsewhere
        for (int y = 0; y < FILL_H; y++) begin
            for (int x = 0; x < FILL_W; x++) begin
                if (x < 4 && y < 4) pv = 8'($urandom_range(0, 100));
                else if (((x >> 1) + (y >> 2)) % 3 == 0) pv = 8'($urandom_range(176, 255));
                else pv = 8'($urandom_range(0, 175));
                send_item(epm_pkg::REQ_WRITE, 7'(x), 7'(y), pv, 1'b0, 8'd0);
            end
        end

        // Walk the directed rows; registers only change once the block is idle
        foreach (DIRECTED_ROWS[i]) begin
            if (DIRECTED_ROWS[i].kind == ROW_CFG) begin
                drain_block();
                write_register(DIRECTED_ROWS[i].cfg_index, DIRECTED_ROWS[i].cfg_data);
            end else begin
                send_item(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].pos_x,
                          DIRECTED_ROWS[i].pos_y, DIRECTED_ROWS[i].pixel,
                          DIRECTED_ROWS[i].use_known, DIRECTED_ROWS[i].known_value);
            end
        end

        // Random phases, each with its own settings and idle pattern
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_block();
            send_idle_pct  = PHASE_SEND_IDLE[p];
            recv_stall_pct = PHASE_RECV_STALL[p];
            write_register(epm_pkg::CFG_IMAGE_WIDTH, PHASE_WIDTH[p]);
            write_register(epm_pkg::CFG_IMAGE_HEIGHT, PHASE_HEIGHT[p]);
            write_register(epm_pkg::CFG_KERNEL_SIZE, PHASE_KERNEL[p]);
            write_register(epm_pkg::CFG_INSIDE_THRESHOLD, PHASE_THRESHOLD[p]);
            w   = clamp_dim(cfg_width, IMG_W);
            h   = clamp_dim(cfg_height, IMG_H);
            kr  = clamp_dim(cfg_kernel, KERN_MAX);
            thr = cfg_threshold;
            n   = 0;
            while (n < ITEMS_PER_PHASE) begin
                // Hold off the receiver for a long stretch while items keep coming
                if (p == 0 && n >= HOLDOFF_START && !holdoff_done) begin
                    holdoff_req++;
                    holdoff_done = 1'b1;
                end
                roll = $urandom_range(0, 99);
                cx   = pick_coord(w);
                cy   = pick_coord(h);
                if (roll < 50) begin
                    send_item(epm_pkg::REQ_COMPUTE, cx, cy, 8'($urandom), 1'b0, 8'd0);
                    n++;
                end else if (roll < 80) begin
                    if ($urandom_range(0, 1) == 0) begin
                        pv = 8'($urandom_range(thr > 4 ? thr - 4 : 0, thr < 251 ? thr + 4 : 255));
                    end else begin
                        pv = 8'($urandom);
                    end
                    send_item(epm_pkg::REQ_WRITE, cx, cy, pv, 1'b0, 8'd0);
                    n++;
                end else begin
                    // Plant a few opposite-class pixels near a point, then query it
                    repeat ($urandom_range(1, 4)) begin
                        t  = int'(cx) + int'($urandom_range(0, 2*kr - 1)) - kr;
                        t  = (t < 0) ? 0 : (t > 127 ? 127 : t);
                        n  = n + 1;
                        if (pixel_mirror[int'(cy)*IMG_W + int'(cx)] > thr)
                            pv = 8'($urandom_range(0, thr));
                        else
                            pv = 8'($urandom_range(thr + 1, 255));
                        send_item(epm_pkg::REQ_WRITE, 7'(t),
                                  7'((int'(cy) + int'($urandom_range(0, 2*kr - 1)) - kr) & 127),
                                  pv, 1'b0, 8'd0);
                    end
                    send_item(epm_pkg::REQ_COMPUTE, cx, cy, 8'($urandom), 1'b0, 8'd0);
                    n++;
                end
            end
        end

        drain_block();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("edge_proximity_map_top test passed");
        end else begin
            $display("edge_proximity_map_top test failed");
        end
        $finish;
    end

    // End the run if it hangs
    initial begin : watchdog
        #3_000_000;
        $display("edge_proximity_map_top test failed");
        $finish;
    end

endmodule

### edge_proximity_map_top.f
src/epm_pkg.sv
src/edge_proximity_map_top.sv
test/edge_proximity_map_top_tb.sv
